### rtl/detection_persistence_filter_defines.svh
// ---------------------------------------------------------------------------
// Detection persistence filter - assertion macros
// Shared property forms for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef DETECTION_PERSISTENCE_FILTER_DEFINES_SVH
`define DETECTION_PERSISTENCE_FILTER_DEFINES_SVH

// same-cycle implication, checked at every rising edge out of reset
`define DPF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dpf_pkg.sv
// ---------------------------------------------------------------------------
// dpf_pkg
// Constants, types and codes shared by the detection persistence filter.
// ---------------------------------------------------------------------------
package dpf_pkg;

  localparam int MAX_TRACKS    = 16;
  localparam int HIT_CEILING   = 8;
  localparam int CONFIRM_LEVEL = 3;

  localparam int IDX_W    = $clog2(MAX_TRACKS);
  localparam int CNT_W    = $clog2(MAX_TRACKS + 1);
  localparam int BOX_W    = 12;
  localparam int COORD_W  = 13;
  localparam int HIT_W    = 4;
  localparam int RADIUS_W = 12;
  localparam int PERIOD_W = 8;
  localparam int SQ_W     = 2 * COORD_W;
  localparam int LIM_W    = 2 * RADIUS_W;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 12'd16;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd10;

  // operation codes
  localparam logic OP_DETECT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // register select, taken from paddr[2]
  localparam logic REG_MATCH_RADIUS = 1'b0;
  localparam logic REG_DECAY_PERIOD = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [HIT_W-1:0]   hits;
  } track_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RAD,
    ST_LIM,
    ST_DX,
    ST_DY,
    ST_CMP,
    ST_HIT,
    ST_APPEND,
    ST_BEST,
    ST_BSCAN,
    ST_BFIN,
    ST_DEC,
    ST_DSCAN,
    ST_OUT
  } state_t;

endpackage

### rtl/dpf_sq_unit.sv
// ---------------------------------------------------------------------------
// dpf_sq_unit
// Shared squaring unit: registered (|a - b|)^2.
// ---------------------------------------------------------------------------
module dpf_sq_unit
  import dpf_pkg::*;
(
  input  logic               clk,
  input  logic [COORD_W-1:0] a,
  input  logic [COORD_W-1:0] b,
  output logic [SQ_W-1:0]    sq
);

  logic [COORD_W-1:0] diff;
  logic [SQ_W-1:0]    sq_r;

  assign diff = (a >= b) ? (a - b) : (b - a);

  always_ff @(posedge clk) begin
    sq_r <= SQ_W'(diff) * SQ_W'(diff);
  end

  assign sq = sq_r;

endmodule

### rtl/detection_persistence_filter.sv
// ---------------------------------------------------------------------------
// detection_persistence_filter
// Track-table persistence filter for object detections.
// ---------------------------------------------------------------------------
// Detection: radius squared, tracks compared in table order up to the first
//   match, hit or append, then a best-track scan; one squaring unit, one mem port.
// Frame tick: bumps the frame counter, or decays and packs the table when due.
// One item at a time (in_ready only while idle): a new item is taken only once the last one's result is registered.
// Reset (sync, active low) empties the table, clears the frame counter and best
//   position, and loads match_radius = 16, decay_period = 10.
// ---------------------------------------------------------------------------
module detection_persistence_filter
  import dpf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input beats
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_operation,
  input  logic [BOX_W-1:0]    in_box_left,
  input  logic [BOX_W-1:0]    in_box_top,
  input  logic [BOX_W-1:0]    in_box_width,
  input  logic [BOX_W-1:0]    in_box_height,
  // result beats
  output logic                out_valid,
  input  logic                out_ready,
  output logic [COORD_W-1:0]  out_best_x,
  output logic [COORD_W-1:0]  out_best_y,
  output logic [CNT_W-1:0]    out_track_count,
  output logic                out_dropped,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  // sequencer and control
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;       // track under scan
  logic [CNT_W-1:0]    w_r, w_nxt;           // compaction write pointer
  logic [CNT_W-1:0]    used_r, used_nxt;
  logic [PERIOD_W-1:0] fc_r, fc_nxt;
  logic [RADIUS_W-1:0] radius_r, radius_nxt;
  logic [PERIOD_W-1:0] decay_r, decay_nxt;
  logic [COORD_W-1:0]  best_col_r, best_col_nxt;
  logic [COORD_W-1:0]  best_row_r, best_row_nxt;
  logic                out_valid_r, out_valid_nxt;

  // working payload
  logic [COORD_W-1:0]  cx_r, cx_nxt;
  logic [COORD_W-1:0]  cy_r, cy_nxt;
  logic [LIM_W-1:0]    lim_r, lim_nxt;
  logic [SQ_W-1:0]     acc_r, acc_nxt;
  logic [HIT_W-1:0]    top_r, top_nxt;
  logic [COORD_W-1:0]  bx_r, bx_nxt;
  logic [COORD_W-1:0]  by_r, by_nxt;
  logic                drop_r, drop_nxt;
  logic [COORD_W-1:0]  obx_r, obx_nxt;
  logic [COORD_W-1:0]  oby_r, oby_nxt;
  logic [CNT_W-1:0]    ocnt_r, ocnt_nxt;
  logic                odrop_r, odrop_nxt;

  // track memory: one write and one registered read per cycle
  track_t              track_mem_r [MAX_TRACKS];
  track_t              rd_r;
  logic                mem_re;
  logic [IDX_W-1:0]    mem_raddr;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  track_t              mem_wdata;

  // shared squaring unit
  logic [COORD_W-1:0]  ua, ub;
  logic [SQ_W-1:0]     sq;

  logic [CNT_W-1:0]    idx_inc;
  logic [PERIOD_W-1:0] fc_inc;
  logic [SQ_W:0]       dist_sum;
  logic                in_match;
  logic [HIT_W-1:0]    hit_dec;
  logic                keep;
  logic                cfg_wr;

  dpf_sq_unit u_sq (
    .clk (clk),
    .a   (ua),
    .b   (ub),
    .sq  (sq)
  );

  assign idx_inc  = idx_r + CNT_W'(1);
  assign fc_inc   = fc_r + PERIOD_W'(1);
  assign dist_sum = {1'b0, acc_r} + {1'b0, sq};
  assign in_match = dist_sum <= (SQ_W + 1)'(lim_r);
  assign hit_dec  = rd_r.hits - HIT_W'(1);
  assign keep     = (hit_dec != '0);
  assign cfg_wr   = psel & penable & pwrite;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    w_nxt         = w_r;
    used_nxt      = used_r;
    fc_nxt        = fc_r;
    radius_nxt    = radius_r;
    decay_nxt     = decay_r;
    best_col_nxt  = best_col_r;
    best_row_nxt  = best_row_r;
    out_valid_nxt = out_valid_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    lim_nxt       = lim_r;
    acc_nxt       = acc_r;
    top_nxt       = top_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    drop_nxt      = drop_r;
    obx_nxt       = obx_r;
    oby_nxt       = oby_r;
    ocnt_nxt      = ocnt_r;
    odrop_nxt     = odrop_r;
    mem_re        = 1'b0;
    mem_raddr     = idx_r[IDX_W-1:0];
    mem_we        = 1'b0;
    mem_waddr     = idx_r[IDX_W-1:0];
    mem_wdata     = '0;
    ua            = cx_r;
    ub            = rd_r.x;
    in_ready      = (state_r == ST_IDLE);

    // result beat taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // register writes: the user must issue them only while idle; the block itself does not enforce this
    if (cfg_wr) begin
      case (paddr[2])
        REG_MATCH_RADIUS: radius_nxt = pwdata[RADIUS_W-1:0];
        REG_DECAY_PERIOD: decay_nxt  = pwdata[PERIOD_W-1:0];
        default:          radius_nxt = radius_r;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cx_nxt   = {1'b0, in_box_left} + {2'b00, in_box_width[BOX_W-1:1]};
          cy_nxt   = {1'b0, in_box_top} + {2'b00, in_box_height[BOX_W-1:1]};
          drop_nxt = 1'b0;
          idx_nxt  = '0;
          w_nxt    = '0;
          if (in_operation == OP_DETECT) begin
            state_nxt = ST_RAD;
          end else if (fc_inc >= decay_r) begin
            fc_nxt    = '0;
            state_nxt = (used_r == '0) ? ST_OUT : ST_DEC;
          end else begin
            fc_nxt    = fc_inc;
            state_nxt = ST_OUT;
          end
        end
      end
      // radius squared, first track fetched alongside
      ST_RAD: begin
        ua        = {1'b0, radius_r};
        ub        = '0;
        mem_re    = 1'b1;
        state_nxt = (used_r == '0) ? ST_APPEND : ST_LIM;
      end
      ST_LIM: begin
        lim_nxt   = sq[LIM_W-1:0];
        state_nxt = ST_DY;
      end
      ST_DX: begin
        state_nxt = ST_DY;
      end
      ST_DY: begin
        ua        = cy_r;
        ub        = rd_r.y;
        acc_nxt   = sq;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (in_match) begin
          state_nxt = ST_HIT;
        end else if (idx_inc < used_r) begin
          idx_nxt   = idx_inc;
          mem_re    = 1'b1;
          mem_raddr = idx_inc[IDX_W-1:0];
          state_nxt = ST_DX;
        end else begin
          state_nxt = ST_APPEND;
        end
      end
      ST_HIT: begin
        mem_we         = 1'b1;
        mem_wdata.x    = cx_r;
        mem_wdata.y    = cy_r;
        mem_wdata.hits = (rd_r.hits < HIT_W'(HIT_CEILING)) ?
                         rd_r.hits + HIT_W'(1) : HIT_W'(HIT_CEILING);
        state_nxt      = ST_BEST;
      end
      ST_APPEND: begin
        if (used_r == CNT_W'(MAX_TRACKS)) begin
          drop_nxt = 1'b1;
        end else begin
          mem_we         = 1'b1;
          mem_waddr      = used_r[IDX_W-1:0];
          mem_wdata.x    = cx_r;
          mem_wdata.y    = cy_r;
          mem_wdata.hits = HIT_W'(1);
          used_nxt       = used_r + CNT_W'(1);
        end
        state_nxt = ST_BEST;
      end
      // best-track scan: rd_r holds entry idx_r, next one fetched meanwhile
      ST_BEST: begin
        idx_nxt   = '0;
        top_nxt   = '0;
        mem_re    = 1'b1;
        mem_raddr = '0;
        state_nxt = ST_BSCAN;
      end
      ST_BSCAN: begin
        if (rd_r.hits > top_r) begin
          top_nxt = rd_r.hits;
          bx_nxt  = rd_r.x;
          by_nxt  = rd_r.y;
        end
        if (idx_inc < used_r) begin
          idx_nxt   = idx_inc;
          mem_re    = 1'b1;
          mem_raddr = idx_inc[IDX_W-1:0];
        end else begin
          state_nxt = ST_BFIN;
        end
      end
      ST_BFIN: begin
        if (top_r > HIT_W'(CONFIRM_LEVEL)) begin
          best_col_nxt = bx_r;
          best_row_nxt = by_r;
        end else begin
          best_col_nxt = '0;
          best_row_nxt = '0;
        end
        state_nxt = ST_OUT;
      end
      // decay: read at idx_r, survivors packed down at w_r (w_r <= idx_r)
      ST_DEC: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        state_nxt = ST_DSCAN;
      end
      ST_DSCAN: begin
        if (keep) begin
          mem_we         = 1'b1;
          mem_waddr      = w_r[IDX_W-1:0];
          mem_wdata.x    = rd_r.x;
          mem_wdata.y    = rd_r.y;
          mem_wdata.hits = hit_dec;
          w_nxt          = w_r + CNT_W'(1);
        end
        if (idx_inc < used_r) begin
          idx_nxt   = idx_inc;
          mem_re    = 1'b1;
          mem_raddr = idx_inc[IDX_W-1:0];
        end else begin
          used_nxt  = w_r + CNT_W'(keep);
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          obx_nxt       = best_col_r;
          oby_nxt       = best_row_r;
          ocnt_nxt      = used_r;
          odrop_nxt     = drop_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      w_r         <= '0;
      used_r      <= '0;
      fc_r        <= '0;
      radius_r    <= RADIUS_RESET;
      decay_r     <= PERIOD_RESET;
      best_col_r  <= '0;
      best_row_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      w_r         <= w_nxt;
      used_r      <= used_nxt;
      fc_r        <= fc_nxt;
      radius_r    <= radius_nxt;
      decay_r     <= decay_nxt;
      best_col_r  <= best_col_nxt;
      best_row_r  <= best_row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    lim_r   <= lim_nxt;
    acc_r   <= acc_nxt;
    top_r   <= top_nxt;
    bx_r    <= bx_nxt;
    by_r    <= by_nxt;
    drop_r  <= drop_nxt;
    obx_r   <= obx_nxt;
    oby_r   <= oby_nxt;
    ocnt_r  <= ocnt_nxt;
    odrop_r <= odrop_nxt;
  end

  // track memory, contents undefined until written
  always_ff @(posedge clk) begin
    if (mem_we) begin
      track_mem_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_r <= track_mem_r[mem_raddr];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_best_x      = obx_r;
  assign out_best_y      = oby_r;
  assign out_track_count = ocnt_r;
  assign out_dropped     = odrop_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DECAY_PERIOD) ? APB_DW'(decay_r) : APB_DW'(radius_r);

endmodule

### rtl/dpf_checker.sv
// ---------------------------------------------------------------------------
// dpf_checker
// Port-level checks on the detection persistence filter, bound to the top.
// ---------------------------------------------------------------------------
`include "detection_persistence_filter_defines.svh"

module dpf_checker
  import dpf_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COORD_W-1:0] out_best_x,
  input logic [COORD_W-1:0] out_best_y,
  input logic [CNT_W-1:0]   out_track_count,
  input logic               out_dropped
);

  logic                         table_full;
  logic                         out_stall;
  logic [2*COORD_W+CNT_W:0]     out_beat;

  assign table_full = (out_track_count == CNT_W'(MAX_TRACKS));
  assign out_stall  = out_valid && !out_ready;
  assign out_beat   = {out_best_x, out_best_y, out_track_count, out_dropped};

  // one item at a time: busy straight after an accepted beat
  `DPF_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

  `DPF_ASSERT_NOW(a_count_range, out_valid, out_track_count <= CNT_W'(MAX_TRACKS), "count range")

  // a drop only happens with a full table
  `DPF_ASSERT_NOW(a_drop_full, out_valid && out_dropped, table_full, "drop not full")

  `DPF_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_beat), "beat moved on stall")

endmodule

bind detection_persistence_filter dpf_checker u_dpf_checker (.*);

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Detection persistence filter testbench
// Sends detection and frame-tick beats under several radius and decay
// settings. A local track-table model predicts every result beat, and each
// result beat is compared field by field with that prediction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dpf_pkg::*;

  localparam int BOX_MAX = (1 << BOX_W) - 1;

  // one result beat as the block should present it
  typedef struct packed {
    logic [COORD_W-1:0] best_x;
    logic [COORD_W-1:0] best_y;
    logic [CNT_W-1:0]   track_count;
    logic               dropped;
  } filter_out_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_operation = OP_DETECT;
  logic [BOX_W-1:0]    in_box_left = '0;
  logic [BOX_W-1:0]    in_box_top = '0;
  logic [BOX_W-1:0]    in_box_width = '0;
  logic [BOX_W-1:0]    in_box_height = '0;

  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [COORD_W-1:0]  out_best_x;
  logic [COORD_W-1:0]  out_best_y;
  logic [CNT_W-1:0]    out_track_count;
  logic                out_dropped;

  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  detection_persistence_filter u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_box_left     (in_box_left),
    .in_box_top      (in_box_top),
    .in_box_width    (in_box_width),
    .in_box_height   (in_box_height),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_best_x      (out_best_x),
    .out_best_y      (out_best_y),
    .out_track_count (out_track_count),
    .out_dropped     (out_dropped),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial forever #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Track-table model: a shadow of the registers and of the table itself.
  // Entries at or above trk_used are never read, so they need no reset.
  // --------------------------------------------------------------------------
  logic [RADIUS_W-1:0] radius_reg = RADIUS_RESET;
  logic [PERIOD_W-1:0] period_reg = PERIOD_RESET;
  logic [COORD_W-1:0]  trk_col [MAX_TRACKS];
  logic [COORD_W-1:0]  trk_row [MAX_TRACKS];
  logic [HIT_W-1:0]    trk_hits [MAX_TRACKS];
  int                  trk_used = 0;
  logic [PERIOD_W-1:0] frame_cnt = '0;
  logic [COORD_W-1:0]  best_col = '0;
  logic [COORD_W-1:0]  best_row = '0;

  filter_out_t         expected_outputs [$];

  int failures = 0;
  int n_results = 0;
  int n_detect = 0;
  int n_tick = 0;
  int n_drop = 0;
  int n_decay = 0;
  int n_confirmed = 0;

  // sender idle gaps and result back-pressure stop for the closing part of the run
  bit quiet = 1'b0;
  int stall_left = 0;

  // Advances the model by one accepted beat and returns the result it causes.
  function automatic filter_out_t predict_persistence(logic op, logic [BOX_W-1:0] left,
                                                      logic [BOX_W-1:0] top,
                                                      logic [BOX_W-1:0] wid,
                                                      logic [BOX_W-1:0] hgt);
    filter_out_t      res;
    logic [COORD_W-1:0] cx, cy;
    logic [HIT_W-1:0] h;
    longint           lim, dx, dy;
    int               i, peak, at, kept;
    bit               matched;
    res = '0;
    matched = 1'b0;
    if (op == OP_DETECT) begin
      n_detect++;
      // centre with each half-size truncated
      cx = COORD_W'(left) + COORD_W'(wid >> 1);
      cy = COORD_W'(top) + COORD_W'(hgt >> 1);
      lim = longint'(radius_reg) * longint'(radius_reg);
      // first track in table order within the radius takes the detection
      for (i = 0; i < trk_used && !matched; i++) begin
        dx = longint'(cx) - longint'(trk_col[i]);
        dy = longint'(cy) - longint'(trk_row[i]);
        if (dx * dx + dy * dy <= lim) begin
          trk_col[i] = cx;
          trk_row[i] = cy;
          if (trk_hits[i] < HIT_CEILING) trk_hits[i] = trk_hits[i] + 1'b1;
          matched = 1'b1;
        end
      end
      if (!matched) begin
        if (trk_used >= MAX_TRACKS) begin
          res.dropped = 1'b1;
          n_drop++;
        end else begin
          trk_col[trk_used] = cx;
          trk_row[trk_used] = cy;
          trk_hits[trk_used] = 1;
          trk_used++;
        end
      end
      // earliest track with the highest count; strict > keeps the earliest
      peak = 0;
      at = 0;
      for (i = 0; i < trk_used; i++) begin
        if (trk_hits[i] > peak) begin
          peak = trk_hits[i];
          at = i;
        end
      end
      if (peak > CONFIRM_LEVEL) begin
        best_col = trk_col[at];
        best_row = trk_row[at];
        n_confirmed++;
      end else begin
        best_col = '0;
        best_row = '0;
      end
    end else begin
      // tick: best position is left as it was
      n_tick++;
      frame_cnt = frame_cnt + 1'b1;
      if (frame_cnt >= period_reg) begin
        n_decay++;
        kept = 0;
        for (i = 0; i < trk_used; i++) begin
          h = trk_hits[i] - 1'b1;
          if (h != 0) begin
            trk_col[kept] = trk_col[i];
            trk_row[kept] = trk_row[i];
            trk_hits[kept] = h;
            kept++;
          end
        end
        trk_used = kept;
        frame_cnt = '0;
      end
    end
    res.best_x = best_col;
    res.best_y = best_row;
    res.track_count = CNT_W'(trk_used);
    return res;
  endfunction

  function automatic void compare_field(string name, logic [APB_DW-1:0] want,
                                        logic [APB_DW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, and a check of every result beat
  // against the oldest prediction still waiting.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 6);
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    filter_out_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (expected_outputs.size() == 0) begin
        $error("result beat with no prediction waiting");
        failures++;
      end else begin
        want = expected_outputs.pop_front();
        compare_field("best_x", APB_DW'(want.best_x), APB_DW'(out_best_x));
        compare_field("best_y", APB_DW'(want.best_y), APB_DW'(out_best_y));
        compare_field("track_count", APB_DW'(want.track_count), APB_DW'(out_track_count));
        compare_field("dropped", APB_DW'(want.dropped), APB_DW'(out_dropped));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side helpers
  // --------------------------------------------------------------------------
  function automatic int idle_gap();
    if (quiet) return 0;
    return ($urandom_range(0, 5) == 0) ? int'($urandom_range(1, 6)) : 0;
  endfunction

  // Presents one beat and waits for it to be taken. Valid is left high after
  // acceptance: the next call either replaces the payload or drops valid for
  // a gap, so valid never falls and rises within one step.
  task automatic send_item(logic op, logic [BOX_W-1:0] left, logic [BOX_W-1:0] top,
                           logic [BOX_W-1:0] wid, logic [BOX_W-1:0] hgt);
    int          gap;
    filter_out_t pred;
    gap = idle_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_operation  <= op;
    in_box_left   <= left;
    in_box_top    <= top;
    in_box_width  <= wid;
    in_box_height <= hgt;
    in_valid      <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pred = predict_persistence(op, left, top, wid, hgt);
    expected_outputs.insert(expected_outputs.size(), pred);
  endtask

  // Detection whose box centre lands on (cx, cy), with a random box size.
  task automatic send_centre(int cx, int cy);
    int wid, hgt;
    if (cx < 0) cx = 0;
    if (cx > BOX_MAX) cx = BOX_MAX;
    if (cy < 0) cy = 0;
    if (cy > BOX_MAX) cy = BOX_MAX;
    wid = $urandom_range(0, (2 * cx + 1 > BOX_MAX) ? BOX_MAX : 2 * cx + 1);
    hgt = $urandom_range(0, (2 * cy + 1 > BOX_MAX) ? BOX_MAX : 2 * cy + 1);
    send_item(OP_DETECT, BOX_W'(cx - wid / 2), BOX_W'(cy - hgt / 2), BOX_W'(wid),
              BOX_W'(hgt));
  endtask

  // Drops valid and waits until every predicted beat has come back.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Register access: setup cycle, then access cycle until pready
  // --------------------------------------------------------------------------
  task automatic reg_readback(logic sel);
    logic [APB_DW-1:0] want, got;
    want = (sel == REG_MATCH_RADIUS) ? APB_DW'(radius_reg) : APB_DW'(period_reg);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= {sel, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = (sel == REG_MATCH_RADIUS) ? APB_DW'(prdata[RADIUS_W-1:0])
                                    : APB_DW'(prdata[PERIOD_W-1:0]);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    compare_field(sel == REG_MATCH_RADIUS ? "match_radius" : "decay_period", want, got);
  endtask

  task automatic reg_write(logic sel, int value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {sel, 2'b00};
    pwdata  <= APB_DW'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (sel == REG_MATCH_RADIUS) radius_reg = RADIUS_W'(value);
    else period_reg = PERIOD_W'(value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_readback(sel);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_reset_registers();
    reg_readback(REG_MATCH_RADIUS);
    reg_readback(REG_DECAY_PERIOD);
  endtask

  // zero box, widest box, odd sizes halved by truncation, tick with
  // every box field at its top (fields must be ignored)
  task automatic test_field_extremes();
    send_item(OP_DETECT, '0, '0, '0, '0);
    send_item(OP_DETECT, BOX_W'(BOX_MAX), BOX_W'(BOX_MAX), BOX_W'(BOX_MAX), BOX_W'(BOX_MAX));
    send_item(OP_DETECT, BOX_W'(100), BOX_W'(200), BOX_W'(3), BOX_W'(1));
    send_item(OP_TICK, BOX_W'(BOX_MAX), BOX_W'(BOX_MAX), BOX_W'(BOX_MAX), BOX_W'(BOX_MAX));
  endtask

  // repeated hits near the far corner track push it past the confirm level
  task automatic test_confirmation();
    repeat (4) send_item(OP_DETECT, BOX_W'(BOX_MAX), BOX_W'(4090), BOX_W'(4089),
                         BOX_W'(BOX_MAX));
  endtask

  // exact-match radius, fill all tracks, then an unmatched detection is
  // dropped while an exact repeat still matches
  task automatic test_table_full();
    int i;
    wait_idle();
    reg_write(REG_MATCH_RADIUS, 0);
    for (i = 0; i < 13; i++) send_centre(300 * i + 150, 4000 - 280 * i);
    send_centre(2222, 1111);
    send_item(OP_DETECT, '0, '0, '0, '0);
    send_item(OP_DETECT, '0, '0, BOX_W'(2), '0);
  endtask

  // zero period: every tick decays, single-hit tracks vanish in order
  task automatic test_zero_period_decay();
    wait_idle();
    reg_write(REG_DECAY_PERIOD, 0);
    repeat (2) send_item(OP_TICK, BOX_W'($urandom), BOX_W'($urandom), BOX_W'($urandom),
                         BOX_W'($urandom));
  endtask

  // One setting of both registers. Most detections cluster round a few
  // targets so tracks build up, confirm, saturate and decay; the rest are
  // ticks and detections with fully random fields.
  task automatic run_phase(int radius, int period, int count, int targets, int pause_at);
    int tx [20];
    int ty [20];
    int jit, k, n, roll;
    wait_idle();
    reg_write(REG_MATCH_RADIUS, radius);
    reg_write(REG_DECAY_PERIOD, period);
    jit = radius / 2;
    if (jit > 24) jit = 24;
    for (k = 0; k < targets; k++) begin
      tx[k] = $urandom_range(0, BOX_MAX);
      ty[k] = $urandom_range(0, BOX_MAX);
    end
    for (n = 0; n < count; n++) begin
      // hold the sender until the block has answered everything
      if (n == pause_at) wait_idle();
      roll = $urandom_range(0, 99);
      if (roll < 14) begin
        send_item(OP_TICK, BOX_W'($urandom), BOX_W'($urandom), BOX_W'($urandom),
                  BOX_W'($urandom));
      end else if (roll < 26) begin
        send_item(OP_DETECT, BOX_W'($urandom), BOX_W'($urandom), BOX_W'($urandom),
                  BOX_W'($urandom));
      end else begin
        k = $urandom_range(0, targets - 1);
        send_centre(tx[k] + int'($urandom_range(0, 2 * jit)) - jit,
                    ty[k] + int'($urandom_range(0, 2 * jit)) - jit);
      end
    end
  endtask

  task automatic test_random_traffic();
    run_phase(RADIUS_RESET, PERIOD_RESET, 120, 3, -1);
    run_phase(0, 255, 100, 20, -1);            // exact match, table fills up
    run_phase(BOX_MAX, 0, 100, 4, -1);         // everything near joins track 0
    run_phase(40, 3, 130, 18, 65);
    run_phase($urandom_range(1, 400), $urandom_range(1, 20), 150, $urandom_range(1, 20), -1);
    quiet = 1'b1;
    run_phase(25, 4, 150, 6, -1);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_registers();
    test_field_extremes();
    test_confirmation();
    test_table_full();
    test_zero_period_decay();
    test_random_traffic();
    wait_idle();
    // any stray beat after the last prediction is caught by the checker
    repeat (80) @(posedge clk);
    if (expected_outputs.size() != 0) begin
      $error("%0d predicted result beats never arrived", expected_outputs.size());
      failures++;
    end
    $display("Run covered %0d detections (%0d dropped on a full table), %0d frame ticks",
             n_detect, n_drop, n_tick);
    $display("and %0d table decays; %0d result beats checked, %0d with a confirmed track.",
             n_decay, n_results, n_confirmed);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // generous ceiling on run length
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/dpf_pkg.sv
rtl/dpf_sq_unit.sv
rtl/detection_persistence_filter.sv
rtl/dpf_checker.sv
tb/testbench.sv
